// ===== sv/glrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid line and rectangle painter package
// Shared widths, codes, handshake types and helper functions.
// ----------------------------------------------------------------------------
package glrp_pkg;

    // Field widths fixed by the item format.
    localparam int POS_W      = 6;
    localparam int CODE_W     = 2;
    localparam int TOOL_W     = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // Bresenham error term: holds values between minus and plus four times the span.
    localparam int ERR_W = POS_W + 3;

    // Default grid size.
    localparam int GRID_W_DEF = 64;
    localparam int GRID_H_DEF = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAINT_TOOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 1'b1;

    // Request kinds.
    localparam logic KIND_CLICK = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Tool codes.
    localparam logic [TOOL_W-1:0] TOOL_NONE    = 3'd0;
    localparam logic [TOOL_W-1:0] TOOL_EDGE    = 3'd1;
    localparam logic [TOOL_W-1:0] TOOL_EMPTY   = 3'd2;
    localparam logic [TOOL_W-1:0] TOOL_RUBBISH = 3'd3;
    localparam logic [TOOL_W-1:0] TOOL_OUT     = 3'd4;

    // Cell codes held in the grid.
    localparam logic [CODE_W-1:0] CELL_EMPTY   = 2'd0;
    localparam logic [CODE_W-1:0] CELL_EDGE    = 2'd1;
    localparam logic [CODE_W-1:0] CELL_RUBBISH = 2'd2;
    localparam logic [CODE_W-1:0] CELL_OUT     = 2'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE  = 2'd0,
        MODE_POINT = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_RECT  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_POINT,
        ST_LINE_INIT,
        ST_LINE_RUN,
        ST_RECT_INIT,
        ST_RECT_RUN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic load_pos;
        logic load_first;
        logic drop_first;
        logic line_init;
        logic line_step;
        logic rect_init;
        logic rect_step;
        logic paint_en;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  req_read;
        logic  click_idle;
        mode_t mode;
        logic  first_pending;
        logic  clear_last;
        logic  line_last;
        logic  rect_last;
        logic  out_free;
    } dp_status_t;

    // True when the tool writes a cell code at all.
    function automatic logic tool_paints(input logic [TOOL_W-1:0] tool);
        logic paints;
        case (tool)
            TOOL_EDGE, TOOL_EMPTY, TOOL_RUBBISH, TOOL_OUT: paints = 1'b1;
            default:                                       paints = 1'b0;
        endcase
        return paints;
    endfunction

    // Cell code written by a tool.
    function automatic logic [CODE_W-1:0] tool_code(input logic [TOOL_W-1:0] tool);
        logic [CODE_W-1:0] code;
        case (tool)
            TOOL_EDGE:    code = CELL_EDGE;
            TOOL_RUBBISH: code = CELL_RUBBISH;
            TOOL_OUT:     code = CELL_OUT;
            default:      code = CELL_EMPTY;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/glrp_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying click and read requests.
// ----------------------------------------------------------------------------
interface glrp_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [glrp_pkg::POS_W-1:0] pos_x;
    logic [glrp_pkg::POS_W-1:0] pos_y;

    modport source (output valid, output kind, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input kind, input pos_x, input pos_y, output ready);
endinterface

// ===== sv/glrp_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the cell code returned by a read.
// ----------------------------------------------------------------------------
interface glrp_out_if;
    logic                        valid;
    logic                        ready;
    logic [glrp_pkg::CODE_W-1:0] cell_code;

    modport source (output valid, output cell_code, input ready);
    modport sink   (input valid, input cell_code, output ready);
endinterface

// ===== sv/glrp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module glrp_ram #(
    parameter  int WIDTH = 2,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/glrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Painter controller
// Sequences clearing, reads, point paints, line runs and rectangle sweeps.
// ----------------------------------------------------------------------------
module glrp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  glrp_pkg::dp_status_t status,
    output glrp_pkg::dp_cmd_t    cmd
);

    glrp_pkg::state_t state_reg;
    glrp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= glrp_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glrp_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = glrp_pkg::ST_IDLE;
                end
            end
            glrp_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (status.req_read)
                    begin
                        state_next = glrp_pkg::ST_RD_ADDR;
                    end
                    else if (!status.click_idle)
                    begin
                        case (status.mode)
                            glrp_pkg::MODE_POINT:
                            begin
                                state_next = glrp_pkg::ST_POINT;
                            end
                            glrp_pkg::MODE_LINE:
                            begin
                                if (status.first_pending)
                                begin
                                    state_next = glrp_pkg::ST_LINE_INIT;
                                end
                            end
                            glrp_pkg::MODE_RECT:
                            begin
                                if (status.first_pending)
                                begin
                                    state_next = glrp_pkg::ST_RECT_INIT;
                                end
                            end
                            default:
                            begin
                                state_next = glrp_pkg::ST_IDLE;
                            end
                        endcase
                    end
                end
            end
            glrp_pkg::ST_RD_ADDR:   state_next = glrp_pkg::ST_RD_DATA;
            glrp_pkg::ST_RD_DATA:
            begin
                if (status.out_free)
                begin
                    state_next = glrp_pkg::ST_IDLE;
                end
            end
            glrp_pkg::ST_POINT:     state_next = glrp_pkg::ST_IDLE;
            glrp_pkg::ST_LINE_INIT: state_next = glrp_pkg::ST_LINE_RUN;
            glrp_pkg::ST_LINE_RUN:
            begin
                if (status.line_last)
                begin
                    state_next = glrp_pkg::ST_IDLE;
                end
            end
            glrp_pkg::ST_RECT_INIT: state_next = glrp_pkg::ST_RECT_RUN;
            glrp_pkg::ST_RECT_RUN:
            begin
                if (status.rect_last)
                begin
                    state_next = glrp_pkg::ST_IDLE;
                end
            end
            default:                state_next = glrp_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            glrp_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            glrp_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_pos = 1'b1;
                    if (!status.req_read && !status.click_idle &&
                        (status.mode inside {glrp_pkg::MODE_LINE, glrp_pkg::MODE_RECT}))
                    begin
                        cmd.drop_first = status.first_pending;
                        cmd.load_first = !status.first_pending;
                    end
                end
            end
            glrp_pkg::ST_RD_DATA:
            begin
                cmd.load_out = status.out_free;
            end
            glrp_pkg::ST_POINT:
            begin
                cmd.paint_en = 1'b1;
            end
            glrp_pkg::ST_LINE_INIT:
            begin
                cmd.line_init = 1'b1;
            end
            glrp_pkg::ST_LINE_RUN:
            begin
                cmd.paint_en  = 1'b1;
                cmd.line_step = !status.line_last;
            end
            glrp_pkg::ST_RECT_INIT:
            begin
                cmd.rect_init = 1'b1;
            end
            glrp_pkg::ST_RECT_RUN:
            begin
                cmd.paint_en  = 1'b1;
                cmd.rect_step = !status.rect_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/glrp_dp.sv =====
// ----------------------------------------------------------------------------
// Painter datapath
// Configuration, cursor, Bresenham stepper, rectangle sweep, grid memory
// and the result register.
// ----------------------------------------------------------------------------
module glrp_dp #(
    parameter int GRID_W = glrp_pkg::GRID_W_DEF,
    parameter int GRID_H = glrp_pkg::GRID_H_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [glrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [glrp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             req_kind,
    input  logic [glrp_pkg::POS_W-1:0]       req_pos_x,
    input  logic [glrp_pkg::POS_W-1:0]       req_pos_y,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic [glrp_pkg::CODE_W-1:0]      res_code,
    input  glrp_pkg::dp_cmd_t                cmd,
    output glrp_pkg::dp_status_t             status
);

    localparam int PW    = glrp_pkg::POS_W;
    localparam int EW    = glrp_pkg::ERR_W;
    localparam int DEPTH = GRID_W * GRID_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(GRID_W + 1);
    localparam int YW    = $clog2(GRID_H + 1);
    localparam int CXW   = (XW > PW) ? XW : PW;
    localparam int CYW   = (YW > PW) ? YW : PW;

    // Configuration.
    logic [glrp_pkg::TOOL_W-1:0] tool_reg, tool_next;
    glrp_pkg::mode_t             mode_reg, mode_next;

    // Two-click state and cursor.
    logic          pending_reg, pending_next;
    logic [PW-1:0] first_x_reg, first_x_next;
    logic [PW-1:0] first_y_reg, first_y_next;
    logic [PW-1:0] cur_x_reg, cur_x_next;
    logic [PW-1:0] cur_y_reg, cur_y_next;

    // Line stepper.
    logic                 steep_reg, steep_next;
    logic                 minor_up_reg, minor_up_next;
    logic [PW-1:0]        dmaj_reg, dmaj_next;
    logic [PW-1:0]        dmin_reg, dmin_next;
    logic [PW-1:0]        cnt_reg, cnt_next;
    logic signed [EW-1:0] err_reg, err_next;

    // Rectangle sweep limits.
    logic [PW-1:0] rect_lx_reg, rect_lx_next;
    logic [PW-1:0] rect_hx_reg, rect_hx_next;
    logic [PW-1:0] rect_hy_reg, rect_hy_next;

    // Clearing pass and result register.
    logic [AW-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [glrp_pkg::CODE_W-1:0]   out_code_reg, out_code_next;

    // Line set-up terms.
    logic                 x_rev, y_rev, steep_c, swap_c;
    logic [PW-1:0]        adx, ady, sx, sy, ex, ey, dmaj_c, dmin_c;
    logic signed [EW-1:0] err_init, err_add_flat, err_add_step;
    logic [PW-1:0]        minor_now, minor_moved;

    // Memory ports.
    logic                        cur_in_grid;
    logic [AW-1:0]               cur_addr;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [glrp_pkg::CODE_W-1:0] ram_wdata;
    logic [glrp_pkg::CODE_W-1:0] ram_rdata;

    assign cur_in_grid = (CXW'(cur_x_reg) < CXW'(GRID_W)) && (CYW'(cur_y_reg) < CYW'(GRID_H));
    assign cur_addr    = AW'(AW'(cur_y_reg) * AW'(GRID_W) + AW'(cur_x_reg));

    // Line set-up from the remembered click and the cursor.
    assign x_rev   = first_x_reg > cur_x_reg;
    assign y_rev   = first_y_reg > cur_y_reg;
    assign adx     = x_rev ? (first_x_reg - cur_x_reg) : (cur_x_reg - first_x_reg);
    assign ady     = y_rev ? (first_y_reg - cur_y_reg) : (cur_y_reg - first_y_reg);
    assign steep_c = ady > adx;
    assign swap_c  = steep_c ? y_rev : x_rev;
    assign sx      = swap_c ? cur_x_reg : first_x_reg;
    assign sy      = swap_c ? cur_y_reg : first_y_reg;
    assign ex      = swap_c ? first_x_reg : cur_x_reg;
    assign ey      = swap_c ? first_y_reg : cur_y_reg;
    assign dmaj_c  = steep_c ? ady : adx;
    assign dmin_c  = steep_c ? adx : ady;
    assign err_init = $signed(EW'({dmin_c, 1'b0})) - $signed(EW'(dmaj_c));

    assign err_add_flat = $signed(EW'({dmin_reg, 1'b0}));
    assign err_add_step = $signed(EW'({dmin_reg, 1'b0})) - $signed(EW'({dmaj_reg, 1'b0}));
    assign minor_now    = steep_reg ? cur_x_reg : cur_y_reg;
    assign minor_moved  = minor_up_reg ? (minor_now + PW'(1)) : (minor_now - PW'(1));

    // Configuration writes.
    always_comb
    begin
        tool_next = tool_reg;
        mode_next = mode_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                glrp_pkg::CFG_PAINT_TOOL:  tool_next = cfg_data;
                glrp_pkg::CFG_SELECT_MODE: mode_next = glrp_pkg::mode_t'(cfg_data[glrp_pkg::MODE_W-1:0]);
                default:                   tool_next = tool_reg;
            endcase
        end
    end

    // Two-click memory.
    always_comb
    begin
        pending_next = pending_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        if (cmd.load_first)
        begin
            pending_next = 1'b1;
            first_x_next = req_pos_x;
            first_y_next = req_pos_y;
        end
        else if (cmd.drop_first)
        begin
            pending_next = 1'b0;
        end
    end

    // Cursor, line stepper and rectangle sweep.
    always_comb
    begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        steep_next    = steep_reg;
        minor_up_next = minor_up_reg;
        dmaj_next     = dmaj_reg;
        dmin_next     = dmin_reg;
        cnt_next      = cnt_reg;
        err_next      = err_reg;
        rect_lx_next  = rect_lx_reg;
        rect_hx_next  = rect_hx_reg;
        rect_hy_next  = rect_hy_reg;
        if (cmd.load_pos)
        begin
            cur_x_next = req_pos_x;
            cur_y_next = req_pos_y;
        end
        else if (cmd.line_init)
        begin
            cur_x_next    = sx;
            cur_y_next    = sy;
            steep_next    = steep_c;
            minor_up_next = steep_c ? (ex >= sx) : (ey >= sy);
            dmaj_next     = dmaj_c;
            dmin_next     = dmin_c;
            cnt_next      = dmaj_c;
            err_next      = err_init;
        end
        else if (cmd.line_step)
        begin
            cnt_next = cnt_reg - PW'(1);
            if (steep_reg)
            begin
                cur_y_next = cur_y_reg + PW'(1);
            end
            else
            begin
                cur_x_next = cur_x_reg + PW'(1);
            end
            if (err_reg < 0)
            begin
                err_next = err_reg + err_add_flat;
            end
            else
            begin
                err_next = err_reg + err_add_step;
                if (steep_reg)
                begin
                    cur_x_next = minor_moved;
                end
                else
                begin
                    cur_y_next = minor_moved;
                end
            end
        end
        else if (cmd.rect_init)
        begin
            cur_x_next   = x_rev ? cur_x_reg : first_x_reg;
            cur_y_next   = y_rev ? cur_y_reg : first_y_reg;
            rect_lx_next = x_rev ? cur_x_reg : first_x_reg;
            rect_hx_next = x_rev ? first_x_reg : cur_x_reg;
            rect_hy_next = y_rev ? first_y_reg : cur_y_reg;
        end
        else if (cmd.rect_step)
        begin
            if (cur_x_reg == rect_hx_reg)
            begin
                cur_x_next = rect_lx_reg;
                cur_y_next = cur_y_reg + PW'(1);
            end
            else
            begin
                cur_x_next = cur_x_reg + PW'(1);
            end
        end
    end

    // Clearing pass and result register.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        if (cmd.clear_en)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_code_next  = cur_in_grid ? ram_rdata : glrp_pkg::CELL_OUT;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tool_reg      <= glrp_pkg::TOOL_NONE;
            mode_reg      <= glrp_pkg::MODE_NONE;
            pending_reg   <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tool_reg      <= tool_next;
            mode_reg      <= mode_next;
            pending_reg   <= pending_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        steep_reg    <= steep_next;
        minor_up_reg <= minor_up_next;
        dmaj_reg     <= dmaj_next;
        dmin_reg     <= dmin_next;
        cnt_reg      <= cnt_next;
        err_reg      <= err_next;
        rect_lx_reg  <= rect_lx_next;
        rect_hx_reg  <= rect_hx_next;
        rect_hy_reg  <= rect_hy_next;
        out_code_reg <= out_code_next;
    end

    // Grid memory: the clearing pass owns the write port until it finishes.
    assign ram_we    = cmd.clear_en || (cmd.paint_en && cur_in_grid && glrp_pkg::tool_paints(tool_reg));
    assign ram_waddr = cmd.clear_en ? clr_cnt_reg : cur_addr;
    assign ram_wdata = cmd.clear_en ? glrp_pkg::CELL_EMPTY : glrp_pkg::tool_code(tool_reg);

    glrp_ram #(
        .WIDTH (glrp_pkg::CODE_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    assign res_valid = out_valid_reg;
    assign res_code  = out_code_reg;

    assign status.req_read      = (req_kind == glrp_pkg::KIND_READ);
    assign status.click_idle    = (tool_reg == glrp_pkg::TOOL_NONE) || (mode_reg == glrp_pkg::MODE_NONE);
    assign status.mode          = mode_reg;
    assign status.first_pending = pending_reg;
    assign status.clear_last    = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.line_last     = (cnt_reg == '0);
    assign status.rect_last     = (cur_x_reg == rect_hx_reg) && (cur_y_reg == rect_hy_reg);
    assign status.out_free      = !out_valid_reg || res_ready;

endmodule

// ===== sv/grid_line_rect_painter.sv =====
// ----------------------------------------------------------------------------
// Grid line and rectangle painter
// Paints points, lines and filled rectangles into a grid of cell codes and
// answers reads of single cells.
// ----------------------------------------------------------------------------
// The block holds a GRID_W by GRID_H grid of two-bit cell codes in a single
// RAM with one write port, and handles one request at a time. After reset a
// clearing pass writes every cell empty, one cell per cycle; no request is
// taken during that pass, though configuration writes are. Lines and
// filled rectangles are painted one cell at a time, because every painted
// cell is one write through the grid RAM's single write port. The result
// of a read sits in an output register, so the block takes further requests
// while that result waits to be collected, until a later read needs it.
//
// Lines are drawn with integer Bresenham stepping in every octant: the
// major axis advances by one cell per cycle and the error term decides when
// the minor axis moves up or down. Paints that fall outside the grid are
// dropped, and a read outside the grid returns the out code. The two-click
// sequence keeps its first click across mode changes.
// ----------------------------------------------------------------------------
module grid_line_rect_painter #(
    parameter int GRID_W = glrp_pkg::GRID_W_DEF,
    parameter int GRID_H = glrp_pkg::GRID_H_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    glrp_in_if.sink                         req,
    glrp_out_if.source                      result,
    input  logic                            cfg_we,
    input  logic [glrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [glrp_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Command and status between the controller and the datapath.
    glrp_pkg::dp_cmd_t    cmd;
    glrp_pkg::dp_status_t status;

    // The controller owns the request handshake and sequences every request.
    glrp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the grid and the result register.
    glrp_dp #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_kind  (req.kind),
        .req_pos_x (req.pos_x),
        .req_pos_y (req.pos_y),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res_code  (result.cell_code),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/glrp_check.sv =====
// ----------------------------------------------------------------------------
// Painter port checker
// Timing and handshake properties seen at the painter's ports.
// ----------------------------------------------------------------------------
module glrp_check (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        req_kind,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [glrp_pkg::CODE_W-1:0] res_code
);

    // A read taken while no result waits comes back once the address and data states have passed,
    // and no other request is taken in between.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_kind == glrp_pkg::KIND_READ) && !res_valid)
        |=> !req_ready ##1 !req_ready ##1 res_valid)
    else $error("read result not delivered three cycles after the request");

    // A click never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_kind == glrp_pkg::KIND_CLICK) && !res_valid)
        |=> !res_valid)
    else $error("click produced a result");

    // A result is not taken away before it is collected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_code)))
    else $error("pending result dropped or changed");

endmodule

bind grid_line_rect_painter glrp_check u_glrp_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_kind  (req.kind),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_code  (result.cell_code)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid line and rectangle painter testbench
// Drives click and read requests into the painter, keeps a shadow copy of
// the grid and the two-click sequence, and checks every returned cell code
// against it, under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int GRID_W = glrp_pkg::GRID_W_DEF;
    localparam int GRID_H = glrp_pkg::GRID_H_DEF;
    localparam int PW     = glrp_pkg::POS_W;
    localparam int DW     = glrp_pkg::CFG_DATA_W;

    // Tool codes above TOOL_OUT carry no cell code; the highest of them.
    localparam logic [glrp_pkg::TOOL_W-1:0] TOOL_NO_CODE_MAX = 3'd7;

    // Cycles without any accepted request or result before the run is
    // declared hung. The clearing pass after reset and a full-grid rectangle
    // are the longest quiet stretches and stay well within this limit.
    localparam int IDLE_LIMIT    = 20000;
    // Length of the deliberate hold-off on the result side.
    localparam int HOLD_CYCLES   = 300;
    // Random requests, the back-pressure burst included.
    localparam int RANDOM_ITEMS  = 750;
    // Extra cycles allowed on top of the estimated work of the last request.
    localparam int SETTLE_MARGIN = 8;

    logic clk = 1'b0;
    logic rst_n;

    logic                                cfg_we;
    logic [glrp_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [glrp_pkg::CFG_DATA_W-1:0]     cfg_data;

    glrp_in_if  req_if ();
    glrp_out_if res_if ();

    grid_line_rect_painter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow of the block: grid contents, registers and the two-click state.
    // ------------------------------------------------------------------------
    logic [glrp_pkg::CODE_W-1:0] shadow_grid [0:GRID_H-1][0:GRID_W-1];
    logic [glrp_pkg::TOOL_W-1:0] tool_reg;
    glrp_pkg::mode_t             mode_reg;
    bit                          first_held;
    int                          first_x;
    int                          first_y;

    // Cell codes that reads have asked for and that have not yet come back.
    logic [glrp_pkg::CODE_W-1:0] codes_due [$];

    // Rough number of cycles the block needs for the most recent request;
    // since it works on one request at a time, only that one can still be busy.
    int last_busy;
    int errors = 0;

    // Handshake between the request side and the result side for the hold-off.
    bit hold_results;
    bit results_held;
    // When set, the request side offers back to back with no gaps.
    bit sender_calm;

    function automatic void shade_cell(input int x, input int y);
        logic [glrp_pkg::CODE_W-1:0] code;
        if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H)
            return;
        case (tool_reg)
            glrp_pkg::TOOL_EDGE:    code = glrp_pkg::CELL_EDGE;
            glrp_pkg::TOOL_EMPTY:   code = glrp_pkg::CELL_EMPTY;
            glrp_pkg::TOOL_RUBBISH: code = glrp_pkg::CELL_RUBBISH;
            glrp_pkg::TOOL_OUT:     code = glrp_pkg::CELL_OUT;
            default:                return;
        endcase
        shadow_grid[y][x] = code;
    endfunction

    // Bresenham in all octants: step along the longer axis, and let the error
    // term decide when the shorter one moves by one towards the far end.
    function automatic void shade_line(input int x0, input int y0, input int x1, input int y1);
        int adx;
        int ady;
        int t;
        int err;
        int dir;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (ady <= adx)
        begin
            if (x0 > x1)
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dir = (y1 >= y0) ? 1 : -1;
            err = 2 * ady - adx;
            shade_cell(x0, y0);
            for (int i = 0; i < adx; i++)
            begin
                x0++;
                if (err < 0)
                    err += 2 * ady;
                else
                begin
                    y0 += dir;
                    err += 2 * (ady - adx);
                end
                shade_cell(x0, y0);
            end
        end
        else
        begin
            if (y0 > y1)
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dir = (x1 >= x0) ? 1 : -1;
            err = 2 * adx - ady;
            shade_cell(x0, y0);
            for (int i = 0; i < ady; i++)
            begin
                y0++;
                if (err < 0)
                    err += 2 * adx;
                else
                begin
                    x0 += dir;
                    err += 2 * (adx - ady);
                end
                shade_cell(x0, y0);
            end
        end
    endfunction

    function automatic void shade_rect(input int lx, input int ly, input int hx, input int hy);
        for (int y = ly; y <= hy; y++)
            for (int x = lx; x <= hx; x++)
                shade_cell(x, y);
    endfunction

    // Applies one accepted request to the shadow. A read queues the cell code
    // it must return, either the one the shadow holds or a fixed one given by
    // the directed table.
    function automatic void apply_request(input logic kind, input int x, input int y,
                                          input bit fixed,
                                          input logic [glrp_pkg::CODE_W-1:0] fixed_code);
        int lx;
        int hx;
        int ly;
        int hy;
        if (kind == glrp_pkg::KIND_READ)
        begin
            codes_due.push_back(fixed ? fixed_code : shadow_grid[y][x]);
            last_busy = 3;
            return;
        end
        last_busy = 1;
        // A dead tool or no mode leaves everything, the held first click too.
        if (tool_reg == glrp_pkg::TOOL_NONE || mode_reg == glrp_pkg::MODE_NONE)
            return;
        if (mode_reg == glrp_pkg::MODE_POINT)
        begin
            shade_cell(x, y);
            last_busy = 2;
        end
        else if (!first_held)
        begin
            first_x    = x;
            first_y    = y;
            first_held = 1'b1;
        end
        else
        begin
            lx = (first_x < x) ? first_x : x;
            hx = (first_x < x) ? x : first_x;
            ly = (first_y < y) ? first_y : y;
            hy = (first_y < y) ? y : first_y;
            if (mode_reg == glrp_pkg::MODE_LINE)
            begin
                shade_line(first_x, first_y, x, y);
                last_busy = 3 + (((hx - lx) > (hy - ly)) ? hx - lx : hy - ly);
            end
            else
            begin
                shade_rect(lx, ly, hx, hy);
                last_busy = 2 + (hx - lx + 1) * (hy - ly + 1);
            end
            first_held = 1'b0;
        end
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // A coordinate within span of centre, clamped to the grid.
    function automatic logic [PW-1:0] jitter(input int centre, input int span, input int top);
        int r;
        int v;
        r = $urandom_range(0, 2 * span);
        v = centre + r - span;
        if (v < 0)
            v = 0;
        if (v > top)
            v = top;
        return v[PW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Offers one request, holding it until the block takes it. Valid is left
    // high so that the next request can follow in the very next cycle.
    task automatic send_request(input logic kind, input logic [PW-1:0] x,
                                input logic [PW-1:0] y, input bit fixed,
                                input logic [glrp_pkg::CODE_W-1:0] fixed_code);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.kind  <= kind;
        req_if.pos_x <= x;
        req_if.pos_y <= y;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        apply_request(kind, int'(x), int'(y), fixed, fixed_code);
    endtask

    // Stops offering, waits for every outstanding read to come back, then
    // gives the block time to finish a line or rectangle that produces no
    // result. Only after this may a register be written.
    task automatic quiesce();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (codes_due.size() != 0)
            @(posedge clk);
        repeat (last_busy + SETTLE_MARGIN) @(posedge clk);
    endtask

    task automatic write_register(input logic [glrp_pkg::CFG_IDX_W-1:0] index,
                                  input logic [DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (index == glrp_pkg::CFG_PAINT_TOOL)
            tool_reg = value;
        else
            mode_reg = glrp_pkg::mode_t'(value[glrp_pkg::MODE_W-1:0]);
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Reads whose answer is obvious carry it in the row;
    // the rest are checked against the shadow.
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_READ_IS
    } row_op_t;

    typedef struct packed {
        row_op_t                        op;
        logic                           kind;
        logic [PW-1:0]                  x;
        logic [PW-1:0]                  y;
        logic [glrp_pkg::CODE_W-1:0]    code;
        logic [glrp_pkg::CFG_IDX_W-1:0] index;
        logic [DW-1:0]                  data;
    } step_t;

    function automatic step_t cfg_row(input logic [glrp_pkg::CFG_IDX_W-1:0] index,
                                      input logic [DW-1:0] data);
        return '{ROW_CFG, glrp_pkg::KIND_CLICK, '0, '0, glrp_pkg::CELL_EMPTY, index, data};
    endfunction

    function automatic step_t click_row(input int x, input int y);
        return '{ROW_REQ, glrp_pkg::KIND_CLICK, x[PW-1:0], y[PW-1:0], glrp_pkg::CELL_EMPTY,
                 '0, '0};
    endfunction

    function automatic step_t read_row(input int x, input int y);
        return '{ROW_REQ, glrp_pkg::KIND_READ, x[PW-1:0], y[PW-1:0], glrp_pkg::CELL_EMPTY,
                 '0, '0};
    endfunction

    function automatic step_t read_is_row(input int x, input int y,
                                          input logic [glrp_pkg::CODE_W-1:0] code);
        return '{ROW_READ_IS, glrp_pkg::KIND_READ, x[PW-1:0], y[PW-1:0], code, '0, '0};
    endfunction

    step_t plan [$];

    initial
    begin
        plan = '{
            // Freshly cleared grid, at both corners.
            read_is_row(0, 0, glrp_pkg::CELL_EMPTY),
            read_is_row(63, 63, glrp_pkg::CELL_EMPTY),
            // A single point at a far corner.
            cfg_row(glrp_pkg::CFG_PAINT_TOOL, glrp_pkg::TOOL_EDGE),
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_POINT}),
            click_row(63, 0),
            read_is_row(63, 0, glrp_pkg::CELL_EDGE),
            // With no tool a click paints nothing.
            cfg_row(glrp_pkg::CFG_PAINT_TOOL, glrp_pkg::TOOL_NONE),
            click_row(0, 63),
            read_is_row(0, 63, glrp_pkg::CELL_EMPTY),
            // Full diagonal across the grid.
            cfg_row(glrp_pkg::CFG_PAINT_TOOL, glrp_pkg::TOOL_OUT),
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_LINE}),
            click_row(0, 0),
            click_row(63, 63),
            read_is_row(32, 32, glrp_pkg::CELL_OUT),
            // Rectangle over the whole grid, corners given anti-diagonally.
            cfg_row(glrp_pkg::CFG_PAINT_TOOL, glrp_pkg::TOOL_RUBBISH),
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_RECT}),
            click_row(63, 0),
            click_row(0, 63),
            read_is_row(17, 45, glrp_pkg::CELL_RUBBISH),
            // A tool without a cell code walks the sequence but paints nothing.
            cfg_row(glrp_pkg::CFG_PAINT_TOOL, TOOL_NO_CODE_MAX),
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_LINE}),
            click_row(10, 10),
            click_row(10, 50),
            read_is_row(10, 30, glrp_pkg::CELL_RUBBISH),
            // First click held across a change to point mode, then used as
            // the first corner of a rectangle.
            cfg_row(glrp_pkg::CFG_PAINT_TOOL, glrp_pkg::TOOL_EMPTY),
            click_row(5, 5),
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_POINT}),
            click_row(40, 40),
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_RECT}),
            click_row(7, 9),
            read_row(6, 7),
            read_row(40, 40),
            // Steep line, then a shallow one, both with y falling as x rises.
            cfg_row(glrp_pkg::CFG_PAINT_TOOL, glrp_pkg::TOOL_EDGE),
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_LINE}),
            click_row(20, 60),
            click_row(25, 3),
            read_row(23, 30),
            click_row(2, 40),
            click_row(60, 35),
            read_row(31, 37),
            // No mode: click ignored.
            cfg_row(glrp_pkg::CFG_SELECT_MODE, {1'b0, glrp_pkg::MODE_NONE}),
            click_row(1, 1),
            read_row(1, 1)
        };
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, one deliberate back-pressure
    // burst, then random phases each with its own tool and mode.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int            done;
        int            burst;
        int            span;
        int            anchor_x;
        int            anchor_y;
        logic          kind;
        logic [PW-1:0] x;
        logic [PW-1:0] y;
        logic          junk;
        int            pick;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= glrp_pkg::CFG_PAINT_TOOL;
        cfg_data     <= '0;
        req_if.valid <= 1'b0;
        req_if.kind  <= glrp_pkg::KIND_CLICK;
        req_if.pos_x <= '0;
        req_if.pos_y <= '0;

        for (int r = 0; r < GRID_H; r++)
            for (int c = 0; c < GRID_W; c++)
                shadow_grid[r][c] = glrp_pkg::CELL_EMPTY;
        tool_reg     = glrp_pkg::TOOL_NONE;
        mode_reg     = glrp_pkg::MODE_NONE;
        first_held   = 1'b0;
        first_x      = 0;
        first_y      = 0;
        last_busy    = 0;
        sender_calm  = 1'b0;
        hold_results = 1'b0;
        anchor_x     = 0;
        anchor_y     = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block is still clearing its grid here; requests simply wait.
        foreach (plan[i])
        begin
            if (plan[i].op == ROW_CFG)
            begin
                quiesce();
                write_register(plan[i].index, plan[i].data);
            end
            else
                send_request(plan[i].kind, plan[i].x, plan[i].y,
                             plan[i].op == ROW_READ_IS, plan[i].code);
        end

        // Back-pressure: the result side holds off for a long stretch while
        // reads are offered back to back, so the output register fills and
        // the block has to refuse further requests.
        quiesce();
        hold_results = 1'b1;
        while (!results_held)
            @(posedge clk);
        sender_calm = 1'b1;
        done = 0;
        for (burst = 0; burst < 16; burst++)
        begin
            send_request(glrp_pkg::KIND_READ, PW'($urandom_range(0, GRID_W - 1)),
                         PW'($urandom_range(0, GRID_H - 1)), 1'b0, glrp_pkg::CELL_EMPTY);
            done++;
        end
        sender_calm = 1'b0;

        while (done < RANDOM_ITEMS)
        begin
            // New phase: wait for the block to go quiet, then pick settings.
            // Painting tools dominate; a dead tool or a code-less one now and then.
            quiesce();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                write_register(glrp_pkg::CFG_PAINT_TOOL, glrp_pkg::TOOL_NONE);
            else if (pick == 1)
                write_register(glrp_pkg::CFG_PAINT_TOOL,
                               DW'($urandom_range(glrp_pkg::TOOL_OUT + 1, TOOL_NO_CODE_MAX)));
            else
                write_register(glrp_pkg::CFG_PAINT_TOOL,
                               DW'($urandom_range(glrp_pkg::TOOL_EDGE, glrp_pkg::TOOL_OUT)));
            // The upper data bit is beyond the mode register and must not matter.
            junk = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_register(glrp_pkg::CFG_SELECT_MODE, {junk, glrp_pkg::MODE_NONE});
            else if (pick < 4)
                write_register(glrp_pkg::CFG_SELECT_MODE, {junk, glrp_pkg::MODE_POINT});
            else if (pick < 7)
                write_register(glrp_pkg::CFG_SELECT_MODE, {junk, glrp_pkg::MODE_LINE});
            else
                write_register(glrp_pkg::CFG_SELECT_MODE, {junk, glrp_pkg::MODE_RECT});
            sender_calm = ($urandom_range(0, 3) == 0);

            for (int n = $urandom_range(12, 40); n > 0 && done < RANDOM_ITEMS; n--)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    // Reads mostly look around the latest click, where
                    // something has probably just been painted.
                    kind = glrp_pkg::KIND_READ;
                    if ($urandom_range(0, 2) != 0)
                    begin
                        x = jitter(anchor_x, 4, GRID_W - 1);
                        y = jitter(anchor_y, 4, GRID_H - 1);
                    end
                    else
                    begin
                        x = PW'($urandom_range(0, GRID_W - 1));
                        y = PW'($urandom_range(0, GRID_H - 1));
                    end
                end
                else
                begin
                    kind = glrp_pkg::KIND_CLICK;
                    // Second clicks land near the first, so rectangles stay
                    // small; only a rare one may span most of the grid.
                    if (first_held && mode_reg == glrp_pkg::MODE_RECT)
                        span = ($urandom_range(0, 49) == 0) ? GRID_W - 1 : 4;
                    else if (first_held && mode_reg == glrp_pkg::MODE_LINE)
                        span = ($urandom_range(0, 4) == 0) ? GRID_W - 1 : 16;
                    else
                        span = 0;
                    if (span != 0)
                    begin
                        x = jitter(first_x, span, GRID_W - 1);
                        y = jitter(first_y, span, GRID_H - 1);
                    end
                    else
                    begin
                        x = PW'($urandom_range(0, GRID_W - 1));
                        y = PW'($urandom_range(0, GRID_H - 1));
                    end
                    anchor_x = int'(x);
                    anchor_y = int'(y);
                end
                done++;
                send_request(kind, x, y, 1'b0, glrp_pkg::CELL_EMPTY);
            end
        end

        // Everything offered: wait for the last results and any trailing paint.
        quiesce();
        if (errors == 0 && codes_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls with calm stretches, plus the one long
    // hold-off requested by the stimulus.
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int gap;
        int calm_left;
        results_held = 1'b0;
        calm_left    = 0;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                hold_results = 1'b0;
                results_held = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                results_held = 1'b0;
            end
            else
            begin
                if (calm_left > 0)
                begin
                    calm_left--;
                    gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 39) == 0)
                        calm_left = $urandom_range(50, 200);
                    gap = pick_gap();
                end
                if (gap == 0)
                begin
                    res_if.ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    res_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // Every returned cell code must match the oldest outstanding read.
    always @(posedge clk)
    begin : result_check
        logic [glrp_pkg::CODE_W-1:0] due;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (codes_due.size() == 0)
            begin
                errors++;
                $display("%0t: cell_code expected none, got %0d", $realtime, res_if.cell_code);
            end
            else
            begin
                due = codes_due.pop_front();
                if (res_if.cell_code !== due)
                begin
                    errors++;
                    $display("%0t: cell_code expected %0d, got %0d",
                             $realtime, due, res_if.cell_code);
                end
            end
        end
    end

    // Hang detection: too long without any request or result moving.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
